FILE: design/aspect_ratio_fit_rect_assert.svh
// ----------------------------------------------------------------------------
// Aspect ratio fit assertion macros
// Shared property templates for the block's checker.
// ----------------------------------------------------------------------------
`ifndef ASPECT_RATIO_FIT_RECT_ASSERT_SVH
`define ASPECT_RATIO_FIT_RECT_ASSERT_SVH

// same-cycle implication, ignored while reset is high
`define AR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, ignored while reset is high
`define AR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// state right after a reset cycle
`define AR_ASSERT_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: design/ar_fit_pkg.sv
// ----------------------------------------------------------------------------
// Aspect ratio fit package
// Widths, alignment codes, pipeline sizing and placement helpers.
// ----------------------------------------------------------------------------
package ar_fit_pkg;

   localparam int POS_W   = 32;
   localparam int SIZE_W  = 31;
   localparam int ALIGN_W = 4;
   localparam int PROD_W  = 2 * SIZE_W;

   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = (SIZE_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIV_REGS   = DIV_STAGES + 1;

   localparam logic [ALIGN_W-1:0] ALIGN_NONE          = 4'd0;
   localparam logic [ALIGN_W-1:0] ALIGN_XMIN_YMIN     = 4'd1;
   localparam logic [ALIGN_W-1:0] ALIGN_XMID_YMIN     = 4'd2;
   localparam logic [ALIGN_W-1:0] ALIGN_XMAX_YMIN     = 4'd3;
   localparam logic [ALIGN_W-1:0] ALIGN_XMIN_YMID     = 4'd4;
   localparam logic [ALIGN_W-1:0] ALIGN_XMID_YMID     = 4'd5;
   localparam logic [ALIGN_W-1:0] ALIGN_XMAX_YMID     = 4'd6;
   localparam logic [ALIGN_W-1:0] ALIGN_XMIN_YMAX     = 4'd7;
   localparam logic [ALIGN_W-1:0] ALIGN_XMID_YMAX     = 4'd8;
   localparam logic [ALIGN_W-1:0] ALIGN_XMAX_YMAX     = 4'd9;

   localparam logic MODE_SLICE = 1'b1;

   localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

   typedef enum logic [1:0] {
      PLACE_MIN,
      PLACE_MID,
      PLACE_MAX
   } place_type;

   typedef struct packed {
      logic signed [POS_W-1:0] tx;
      logic signed [POS_W-1:0] ty;
      logic [SIZE_W-1:0]       tw;
      logic [SIZE_W-1:0]       th;
      logic [ALIGN_W-1:0]      align;
      logic                    slice;
      logic                    sw_zero;
      logic                    sh_zero;
   } side_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos;
      logic                    sat;
   } place_res_type;

   function automatic place_type align_x_place(input logic [ALIGN_W-1:0] a);
      place_type p;
      case (a)
         ALIGN_XMID_YMIN, ALIGN_XMID_YMID, ALIGN_XMID_YMAX: p = PLACE_MID;
         ALIGN_XMAX_YMIN, ALIGN_XMAX_YMID, ALIGN_XMAX_YMAX: p = PLACE_MAX;
         default: p = PLACE_MIN;
      endcase
      return p;
   endfunction

   function automatic place_type align_y_place(input logic [ALIGN_W-1:0] a);
      place_type p;
      case (a)
         ALIGN_XMIN_YMID, ALIGN_XMID_YMID, ALIGN_XMAX_YMID: p = PLACE_MID;
         ALIGN_XMIN_YMAX, ALIGN_XMID_YMAX, ALIGN_XMAX_YMAX: p = PLACE_MAX;
         default: p = PLACE_MIN;
      endcase
      return p;
   endfunction

   // origin + diff (max), origin + diff/2 toward zero (mid), origin (min)
   function automatic place_res_type place_pos(input logic signed [POS_W-1:0] org,
                                               input logic signed [POS_W-1:0] diff,
                                               input place_type sel);
      place_res_type r;
      logic signed [POS_W-1:0] addend;
      logic                    cin;
      logic signed [POS_W:0]   sum;
      addend = diff;
      cin    = 1'b0;
      if (sel == PLACE_MID) begin
         addend = diff >>> 1;
         cin    = diff[POS_W-1] & diff[0];
      end
      sum = {org[POS_W-1], org} + {addend[POS_W-1], addend} + {{POS_W{1'b0}}, cin};
      if (sel == PLACE_MIN) begin
         sum = {org[POS_W-1], org};
      end
      r.sat = sum[POS_W] != sum[POS_W-1];
      r.pos = sum[POS_W-1:0];
      if (r.sat) begin
         r.pos = sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

FILE: design/aspect_ratio_fit_rect.sv
// ----------------------------------------------------------------------------
// Aspect ratio fit rectangle
// Fits a source aspect ratio into a target rectangle (meet or slice) and
// places it at min, mid or max on each axis.
// ----------------------------------------------------------------------------
// Takes one item per cycle while req_stall is low. Each result passes
// through one multiply stage, the two parallel 31-bit restoring dividers
// (four quotient bits per stage), a select stage and a placement stage.
// A stall on the result side backs up only as far as the bubbles allow.
// ----------------------------------------------------------------------------
module aspect_ratio_fit_rect import ar_fit_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [POS_W-1:0] req_target_x,
   input  logic signed [POS_W-1:0] req_target_y,
   input  logic [SIZE_W-1:0]       req_target_width,
   input  logic [SIZE_W-1:0]       req_target_height,
   input  logic signed [POS_W-1:0] req_source_x,
   input  logic signed [POS_W-1:0] req_source_y,
   input  logic [SIZE_W-1:0]       req_source_width,
   input  logic [SIZE_W-1:0]       req_source_height,
   input  logic [ALIGN_W-1:0]      req_align,
   input  logic                    req_mode,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [POS_W-1:0] rsp_fit_x,
   output logic signed [POS_W-1:0] rsp_fit_y,
   output logic [SIZE_W-1:0]       rsp_fit_width,
   output logic [SIZE_W-1:0]       rsp_fit_height,
   output logic                    rsp_divide_fault
);

   localparam int SEL_STG = DIV_REGS + 1;
   localparam int OUT_STG = DIV_REGS + 2;
   localparam int NSTG    = DIV_REGS + 3;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG-1:0] rdy;

   always_comb begin
      rdy[NSTG-1] = !vld_ff[NSTG-1] || !rsp_stall;
      for (int k = NSTG - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[0] = req_valid;
      for (int k = 1; k < NSTG; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[OUT_STG];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // multiply stage; source position is not used by the fit
   logic [PROD_W-1:0] prod_h_ff, prod_w_ff;
   logic [SIZE_W-1:0] sw_ff, sh_ff;
   side_type          side_ff [DIV_REGS+1];
   side_type          side_in;
   logic [POS_W-1:0]  unused_src;

   assign unused_src = req_source_x ^ req_source_y;

   always_comb begin
      side_in.tx      = req_target_x;
      side_in.ty      = req_target_y;
      side_in.tw      = req_target_width;
      side_in.th      = req_target_height;
      side_in.align   = req_align;
      side_in.slice   = req_mode == MODE_SLICE;
      side_in.sw_zero = req_source_width == '0;
      side_in.sh_zero = req_source_height == '0 || unused_src != unused_src;
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         prod_h_ff  <= PROD_W'(req_target_width) * PROD_W'(req_source_height);
         prod_w_ff  <= PROD_W'(req_target_height) * PROD_W'(req_source_width);
         sw_ff      <= req_source_width;
         sh_ff      <= req_source_height;
         side_ff[0] <= side_in;
      end
      for (int k = 1; k <= DIV_REGS; k++) begin
         if (rdy[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   logic [SIZE_W-1:0] q_h, q_w;
   logic              ovf_h, ovf_w;

   ar_fit_div u_div_h (
      .clock    (clock),
      .load     (rdy[DIV_REGS:1]),
      .dividend (prod_h_ff),
      .divisor  (sw_ff),
      .quotient (q_h),
      .over     (ovf_h)
   );

   ar_fit_div u_div_w (
      .clock    (clock),
      .load     (rdy[DIV_REGS:1]),
      .dividend (prod_w_ff),
      .divisor  (sh_ff),
      .quotient (q_w),
      .over     (ovf_w)
   );

   // select stage
   side_type                s;
   logic                    active, redo, pass, fault_in;
   logic [SIZE_W-1:0]       fw_in, fh_in;
   place_type               xsel_in, ysel_in;
   logic signed [POS_W-1:0] dx_in, dy_in;

   always_comb begin
      s      = side_ff[DIV_REGS];
      active = s.align >= ALIGN_XMIN_YMIN && s.align <= ALIGN_XMAX_YMAX;
      redo   = s.slice ? (!ovf_h && q_h < s.th) : (ovf_h || q_h > s.th);
      pass   = !active || s.sw_zero || (redo && s.sh_zero);
      fault_in = active && (s.sw_zero || (redo && s.sh_zero) ||
                 (!pass && (redo ? ovf_w : ovf_h)));
      if (pass) begin
         fw_in = s.tw;
         fh_in = s.th;
      end else if (redo) begin
         fw_in = ovf_w ? SIZE_MAX : q_w;
         fh_in = s.th;
      end else begin
         fw_in = s.tw;
         fh_in = ovf_h ? SIZE_MAX : q_h;
      end
      xsel_in = pass ? PLACE_MIN : align_x_place(s.align);
      ysel_in = pass ? PLACE_MIN : align_y_place(s.align);
      dx_in   = {1'b0, s.tw} - {1'b0, fw_in};
      dy_in   = {1'b0, s.th} - {1'b0, fh_in};
   end

   logic signed [POS_W-1:0] tx_ff, ty_ff, dx_ff, dy_ff;
   logic [SIZE_W-1:0]       fw_ff, fh_ff;
   place_type               xsel_ff, ysel_ff;
   logic                    fault_ff;

   always_ff @(posedge clock) begin
      if (rdy[SEL_STG]) begin
         tx_ff    <= s.tx;
         ty_ff    <= s.ty;
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         fw_ff    <= fw_in;
         fh_ff    <= fh_in;
         xsel_ff  <= xsel_in;
         ysel_ff  <= ysel_in;
         fault_ff <= fault_in;
      end
   end

   // placement stage
   place_res_type px, py;

   always_comb begin
      px = place_pos(tx_ff, dx_ff, xsel_ff);
      py = place_pos(ty_ff, dy_ff, ysel_ff);
   end

   logic signed [POS_W-1:0] fx_ff, fy_ff;
   logic [SIZE_W-1:0]       ow_ff, oh_ff;
   logic                    ofault_ff;

   always_ff @(posedge clock) begin
      if (rdy[OUT_STG]) begin
         fx_ff     <= px.pos;
         fy_ff     <= py.pos;
         ow_ff     <= fw_ff;
         oh_ff     <= fh_ff;
         ofault_ff <= fault_ff || px.sat || py.sat;
      end
   end

   assign rsp_fit_x        = fx_ff;
   assign rsp_fit_y        = fy_ff;
   assign rsp_fit_width    = ow_ff;
   assign rsp_fit_height   = oh_ff;
   assign rsp_divide_fault = ofault_ff;

endmodule

FILE: design/ar_fit_div.sv
// ----------------------------------------------------------------------------
// Aspect ratio fit divider
// Pipelined restoring divider, product / divisor, with an overflow flag when
// the quotient does not fit the size range. Several quotient bits per stage.
// ----------------------------------------------------------------------------
module ar_fit_div import ar_fit_pkg::*; (
   input  logic                clock,
   input  logic [DIV_REGS-1:0] load,
   input  logic [PROD_W-1:0]   dividend,
   input  logic [SIZE_W-1:0]   divisor,
   output logic [SIZE_W-1:0]   quotient,
   output logic                over
);

   logic [SIZE_W-1:0] rem_ff [DIV_REGS];
   logic [SIZE_W-1:0] low_ff [DIV_REGS];
   logic [SIZE_W-1:0] quo_ff [DIV_REGS];
   logic [SIZE_W-1:0] div_ff [DIV_REGS];
   logic              ovf_ff [DIV_REGS];

   logic [SIZE_W-1:0] rem_in [DIV_REGS];
   logic [SIZE_W-1:0] low_in [DIV_REGS];
   logic [SIZE_W-1:0] quo_in [DIV_REGS];

   always_comb begin
      rem_in[0] = dividend[PROD_W-1:SIZE_W];
      low_in[0] = dividend[SIZE_W-1:0];
      quo_in[0] = '0;
   end

   for (genvar s = 1; s < DIV_REGS; s++) begin : g_stage
      always_comb begin
         logic [SIZE_W-1:0] r;
         logic [SIZE_W-1:0] l;
         logic [SIZE_W-1:0] q;
         logic [SIZE_W:0]   t;
         r = rem_ff[s-1];
         l = low_ff[s-1];
         q = quo_ff[s-1];
         for (int j = 0; j < DIV_STEPS; j++) begin
            if ((s - 1) * DIV_STEPS + j < SIZE_W) begin
               t = {r, l[SIZE_W-1]};
               l = {l[SIZE_W-2:0], 1'b0};
               if (t >= {1'b0, div_ff[s-1]}) begin
                  t = t - {1'b0, div_ff[s-1]};
                  q = {q[SIZE_W-2:0], 1'b1};
               end else begin
                  q = {q[SIZE_W-2:0], 1'b0};
               end
               r = t[SIZE_W-1:0];
            end
         end
         rem_in[s] = r;
         low_in[s] = l;
         quo_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         rem_ff[0] <= rem_in[0];
         low_ff[0] <= low_in[0];
         quo_ff[0] <= quo_in[0];
         div_ff[0] <= divisor;
         ovf_ff[0] <= dividend[PROD_W-1:SIZE_W] >= divisor;
      end
      for (int s = 1; s < DIV_REGS; s++) begin
         if (load[s]) begin
            rem_ff[s] <= rem_in[s];
            low_ff[s] <= low_in[s];
            quo_ff[s] <= quo_in[s];
            div_ff[s] <= div_ff[s-1];
            ovf_ff[s] <= ovf_ff[s-1];
         end
      end
   end

   assign quotient = quo_ff[DIV_REGS-1];
   assign over     = ovf_ff[DIV_REGS-1];

endmodule

FILE: design/ar_fit_checker.sv
// ----------------------------------------------------------------------------
// Aspect ratio fit checker
// Port-level checks on the result and request channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "aspect_ratio_fit_rect_assert.svh"

module ar_fit_checker import ar_fit_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [POS_W-1:0] rsp_fit_x,
   input logic signed [POS_W-1:0] rsp_fit_y,
   input logic [SIZE_W-1:0]       rsp_fit_width,
   input logic [SIZE_W-1:0]       rsp_fit_height,
   input logic                    rsp_divide_fault
);

   `AR_ASSERT_RESET(a_reset_empty, clock, reset, !rsp_valid)

   `AR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable({rsp_fit_x, rsp_fit_y, rsp_fit_width, rsp_fit_height, rsp_divide_fault}))

   `AR_ASSERT_NOW(a_no_backpressure, clock, reset, !rsp_stall, !req_stall)

endmodule

bind aspect_ratio_fit_rect ar_fit_checker u_ar_fit_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_fit_x        (rsp_fit_x),
   .rsp_fit_y        (rsp_fit_y),
   .rsp_fit_width    (rsp_fit_width),
   .rsp_fit_height   (rsp_fit_height),
   .rsp_divide_fault (rsp_divide_fault)
);

FILE: verif/tb_aspect_ratio_fit_rect.sv
// ----------------------------------------------------------------------------
// Aspect ratio fit rectangle testbench
// Drives target/source rectangles with every alignment and both modes, with
// random gaps and output stalls, and checks each result field against a
// behavioral fit computed in the bench.
// ----------------------------------------------------------------------------
module tb_aspect_ratio_fit_rect;
   import ar_fit_pkg::*;

   typedef struct {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic [SIZE_W-1:0]       w;
      logic [SIZE_W-1:0]       h;
      logic                    fault;
   } fit_rect_type;

   class fit_scoreboard;
      fit_rect_type pending[$];
      int           errors;
      int           checked;

      function logic signed [POS_W-1:0] place(longint org, longint ts, longint fs,
                                              int sel, ref logic flt);
         longint d, v;
         d = ts - fs;
         if (sel == 0) v = org;
         else if (sel == 1) v = org + d / 2;
         else v = org + d;
         if (v > 64'sh7FFFFFFF) begin
            flt = 1'b1;
            v = 64'sh7FFFFFFF;
         end else if (v < -64'sh80000000) begin
            flt = 1'b1;
            v = -64'sh80000000;
         end
         return v[POS_W-1:0];
      endfunction

      function void note_request(logic signed [POS_W-1:0] tx, logic signed [POS_W-1:0] ty,
                                 logic [SIZE_W-1:0] tw, logic [SIZE_W-1:0] th,
                                 logic [SIZE_W-1:0] sw, logic [SIZE_W-1:0] sh,
                                 logic [ALIGN_W-1:0] al, logic md);
         fit_rect_type r;
         longint unsigned w, h;
         logic redo;
         int code;
         r.x = tx; r.y = ty; r.w = tw; r.h = th; r.fault = 1'b0;
         if (al >= ALIGN_XMIN_YMIN && al <= ALIGN_XMAX_YMAX) begin
            if (sw == 0) r.fault = 1'b1;
            else begin
               w = 64'(tw);
               h = (longint'(tw) * sh) / sw;
               redo = (md == MODE_SLICE) ? (h < th) : (h > th);
               if (redo && sh == 0) r.fault = 1'b1;
               else begin
                  if (redo) begin
                     h = 64'(th);
                     w = (longint'(th) * sw) / sh;
                  end
                  if (w > SIZE_MAX) begin w = 64'(SIZE_MAX); r.fault = 1'b1; end
                  if (h > SIZE_MAX) begin h = 64'(SIZE_MAX); r.fault = 1'b1; end
                  r.w = SIZE_W'(w); r.h = SIZE_W'(h);
                  code = al - 1;
                  r.x = place(longint'(tx), longint'(tw), longint'(w), code % 3, r.fault);
                  r.y = place(longint'(ty), longint'(th), longint'(h), code / 3, r.fault);
               end
            end
         end
         pending.push_back(r);
      endfunction

      function void check_result(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                                 logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h, logic f);
         fit_rect_type e;
         checked++;
         if (pending.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (x !== e.x) begin $error("fit_x exp %0d got %0d", e.x, x); errors++; end
         if (y !== e.y) begin $error("fit_y exp %0d got %0d", e.y, y); errors++; end
         if (w !== e.w) begin $error("fit_width exp %0d got %0d", e.w, w); errors++; end
         if (h !== e.h) begin $error("fit_height exp %0d got %0d", e.h, h); errors++; end
         if (f !== e.fault) begin
            $error("divide_fault exp %0b got %0b", e.fault, f);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [POS_W-1:0] req_target_x = '0, req_target_y = '0;
   logic [SIZE_W-1:0] req_target_width = '0, req_target_height = '0;
   logic signed [POS_W-1:0] req_source_x = '0, req_source_y = '0;
   logic [SIZE_W-1:0] req_source_width = '0, req_source_height = '0;
   logic [ALIGN_W-1:0] req_align = ALIGN_NONE;
   logic req_mode = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [POS_W-1:0] rsp_fit_x, rsp_fit_y;
   logic [SIZE_W-1:0] rsp_fit_width, rsp_fit_height;
   logic rsp_divide_fault;

   fit_scoreboard sb = new();
   int  cycles;
   int  sent;
   int  stall_left;
   bit  quiet_stall;

   aspect_ratio_fit_rect uut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("aspect_ratio_fit_rect test failed");
         $finish;
      end
   end

   function int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // short random stalls, with an occasional long one
   always @(posedge clock) begin
      if (reset || quiet_stall) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 2) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(8, 40);
      end else begin
         rsp_stall <= ($urandom_range(0, 9) < 3);
      end
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_fit_x, rsp_fit_y, rsp_fit_width, rsp_fit_height,
                         rsp_divide_fault);
   end

   task automatic send_item(logic [31:0] tx, logic [31:0] ty, logic [30:0] tw,
                            logic [30:0] th, logic [30:0] sw, logic [30:0] sh,
                            logic [3:0] al, logic md);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_target_x <= tx;
      req_target_y <= ty;
      req_target_width <= tw;
      req_target_height <= th;
      req_source_x <= $urandom();
      req_source_y <= $urandom();
      req_source_width <= sw;
      req_source_height <= sh;
      req_align <= al;
      req_mode <= md;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(tx, ty, tw, th, sw, sh, al, md);
      sent++;
   endtask

   function logic [30:0] rand_size();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 31'($urandom_range(0, 3));
      if (r < 3) return 31'($urandom() >> 1);
      if (r < 6) return 31'($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 30));
      return 31'($urandom_range(1, 1000) << 16);
   endfunction

   initial begin
      logic [30:0] mx;
      mx = SIZE_MAX;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int a = 0; a < 10; a++)
         send_item(32'h0001_0000, 32'hFFFF_0000, 31'd200 << 16, 31'd100 << 16,
                   31'd50 << 16, 31'd50 << 16, ALIGN_W'(a), 1'(a % 2));
      send_item(32'h7FFF_FFFF, 32'h8000_0000, mx, 31'd1, 31'd1, mx, ALIGN_XMAX_YMAX, 1'b1);
      send_item(32'h8000_0000, 32'h7FFF_FFFF, mx, mx, 31'd1, 31'd3, ALIGN_XMID_YMID, 1'b0);
      send_item(32'h0, 32'h0, 31'd100, 31'd100, 31'd0, 31'd5, ALIGN_XMIN_YMIN, 1'b0);
      send_item(32'h0, 32'h0, 31'd100, 31'd10, 31'd5, 31'd0, ALIGN_XMID_YMID, 1'b1);
      send_item(32'h0, 32'h0, 31'd10, 31'd100, 31'd5, 31'd0, ALIGN_XMID_YMID, 1'b0);
      send_item(32'h1234, 32'h5678, 31'd77, 31'd88, 31'd0, 31'd0, 4'd15, 1'b1);
      send_item(32'h1234, 32'h5678, 31'd77, 31'd88, 31'd3, 31'd4, 4'd10, 1'b0);
      send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd1, 31'd1, mx, 31'd1,
                ALIGN_XMAX_YMAX, 1'b1);
      send_item(32'h8000_0000, 32'h8000_0000, 31'd0, 31'd0, 31'd1, 31'd1,
                ALIGN_XMID_YMAX, 1'b0);
      send_item(32'hFFFF_FFFF, 32'h0, mx, mx, mx, mx, ALIGN_XMAX_YMIN, 1'b1);
      for (int i = 0; i < 1950; i++) begin
         quiet_stall = (i / 200) % 4 == 3;
         send_item($urandom(), ($urandom_range(0, 3) == 0) ? $urandom() : $urandom() >> 2,
                   rand_size(), rand_size(), rand_size(), rand_size(),
                   ($urandom_range(0, 19) == 0) ? ALIGN_W'($urandom_range(0, 15))
                                                : ALIGN_W'($urandom_range(1, 9)),
                   1'($urandom_range(0, 1)));
      end
      req_valid <= 1'b0;
      quiet_stall = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("Sent %0d transfers over all alignments and both modes, checked %0d results.",
               sent, sb.checked);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("aspect_ratio_fit_rect test passed");
      else
         $display("aspect_ratio_fit_rect test failed");
      $finish;
   end
endmodule
